// ===== src/lzbd_pkg.sv =====
// Shared types and constants for the LZSS block stream decoder.
// Used by the front end, the command queue, the back end and the top level.
package lzbd_pkg;

  localparam int OFF_W  = 12;
  localparam int LEN_W  = 5;
  localparam int SIZE_W = 32;
  localparam int BYTE_W = 8;

  localparam int DEF_RING_SIZE = 4096;
  localparam int DEF_MAX_MATCH = 18;
  localparam int DEF_CMD_DEPTH = 4;

  localparam int LEN_BIAS = 3;
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

  localparam int TU_VALID = 0;
  localparam int TU_DONE  = 1;
  localparam int TU_OVF   = 2;
  localparam int TU_W     = 3;

  typedef struct packed {
    logic              init;
    logic              from_ring;
    logic              wr;
    logic              empty;
    logic              done;
    logic [BYTE_W-1:0] data;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  take;
  } cmd_t;

endpackage

// ===== src/lzbd_front.sv =====
// Front end: accepts stream bytes, parses block headers and flag bits,
// tracks the output byte budget and issues one command per beat.
// Depends on lzbd_pkg.
module lzbd_front
  import lzbd_pkg::*;
#(
  parameter int RING_SIZE = DEF_RING_SIZE,
  parameter int MAX_MATCH = DEF_MAX_MATCH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              in_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              fifo_full
);

  localparam logic [2:0] PH_HDR_HI = 3'd0;
  localparam logic [2:0] PH_HDR_LO = 3'd1;
  localparam logic [2:0] PH_RAW    = 3'd2;
  localparam logic [2:0] PH_TOKEN  = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_MATCH2 = 3'd5;

  localparam logic [3:0] FLAG_BITS = 4'd8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MATCH);

  logic [2:0]        phase_r, phase_nxt, ph_e;
  logic [7:0]        hh_r, hh_nxt, hh_e;
  logic [15:0]       bbl_r, bbl_nxt, bbl_e, bbl_dec;
  logic [7:0]        fs_r, fs_nxt, fs_e;
  logic [3:0]        fl_r, fl_nxt, fl_e;
  logic [7:0]        mfb_r, mfb_nxt, mfb_e;
  logic [SIZE_W-1:0] bw_r, bw_nxt, bw_e;
  logic              fin_r, fin_nxt, fin_e;
  logic [SIZE_W-1:0] size_r;

  logic              accept, fin0, bw_ge, sum_ge;
  logic              end_mark, emit_lit, emit_match, emit_raw, init_ring;
  logic [7:0]        lit_byte, m_b0, m_b1;
  logic [15:0]       hdr;
  logic [LEN_W-1:0]  nib_len, n_match, n_emit, take;
  logic [SIZE_W:0]   sum;
  logic [SIZE_W-1:0] diff;
  logic [16:0]       off_red;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !fifo_full;
  assign cfg_ready = 1'b1;

  assign ph_e  = in_tuser ? PH_HDR_HI : phase_r;
  assign hh_e  = in_tuser ? 8'd0 : hh_r;
  assign bbl_e = in_tuser ? 16'd0 : bbl_r;
  assign fs_e  = in_tuser ? 8'd0 : fs_r;
  assign fl_e  = in_tuser ? 4'd0 : fl_r;
  assign mfb_e = in_tuser ? 8'd0 : mfb_r;
  assign bw_e  = in_tuser ? '0 : bw_r;
  assign fin_e = in_tuser ? 1'b0 : fin_r;

  assign bw_ge = bw_e >= size_r;
  assign fin0  = fin_e || (ph_e == PH_HDR_HI && bw_ge);
  assign hdr   = {hh_e, in_tdata};
  assign bbl_dec = (bbl_e == 16'd0) ? 16'd0 : bbl_e - 16'd1;

  always_comb begin
    phase_nxt  = ph_e;
    hh_nxt     = hh_e;
    bbl_nxt    = bbl_e;
    fs_nxt     = fs_e;
    fl_nxt     = fl_e;
    mfb_nxt    = mfb_e;
    end_mark   = 1'b0;
    emit_lit   = 1'b0;
    emit_match = 1'b0;
    emit_raw   = 1'b0;
    init_ring  = 1'b0;
    lit_byte   = in_tdata;
    m_b0       = 8'd0;
    m_b1       = 8'd0;
    if (!fin0) begin
      case (ph_e)
        PH_HDR_HI: begin
          hh_nxt    = in_tdata;
          phase_nxt = PH_HDR_LO;
        end
        PH_HDR_LO: begin
          if (hdr == 16'd0) begin
            end_mark  = 1'b1;
            phase_nxt = PH_HDR_HI;
          end else if (hdr[15]) begin
            bbl_nxt   = 16'd0 - hdr;
            phase_nxt = PH_RAW;
          end else begin
            bbl_nxt   = hdr;
            init_ring = 1'b1;
            fs_nxt    = 8'd0;
            fl_nxt    = 4'd0;
            phase_nxt = PH_TOKEN;
          end
        end
        PH_RAW: begin
          emit_raw = 1'b1;
          bbl_nxt  = bbl_dec;
          if (bbl_dec == 16'd0) begin
            phase_nxt = PH_HDR_HI;
          end
        end
        PH_TOKEN, PH_BODY, PH_MATCH2: begin
          bbl_nxt = bbl_dec;
          if (ph_e == PH_TOKEN && fl_e == 4'd0) begin
            fs_nxt    = in_tdata;
            fl_nxt    = FLAG_BITS;
            phase_nxt = PH_BODY;
            if (bbl_dec == 16'd0) begin
              fs_nxt    = {1'b0, in_tdata[7:1]};
              fl_nxt    = FLAG_BITS - 4'd1;
              phase_nxt = PH_HDR_HI;
              if (in_tdata[0]) begin
                emit_lit = 1'b1;
                lit_byte = 8'd0;
              end else begin
                mfb_nxt    = 8'd0;
                emit_match = 1'b1;
              end
            end
          end else if (ph_e != PH_MATCH2) begin
            fs_nxt = {1'b0, fs_e[7:1]};
            fl_nxt = (fl_e == 4'd0) ? 4'd0 : fl_e - 4'd1;
            if (fs_e[0]) begin
              emit_lit  = 1'b1;
              phase_nxt = PH_TOKEN;
            end else begin
              mfb_nxt   = in_tdata;
              phase_nxt = PH_MATCH2;
              if (bbl_dec == 16'd0) begin
                emit_match = 1'b1;
                m_b0       = in_tdata;
              end
            end
            if (bbl_dec == 16'd0) begin
              phase_nxt = PH_HDR_HI;
            end
          end else begin
            emit_match = 1'b1;
            m_b0       = mfb_e;
            m_b1       = in_tdata;
            phase_nxt  = (bbl_dec == 16'd0) ? PH_HDR_HI : PH_TOKEN;
          end
        end
        default: begin
          phase_nxt = PH_HDR_HI;
        end
      endcase
    end
  end

  always_comb begin
    off_red = {5'd0, m_b1[7:4], m_b0};
    for (int s = 3; s >= 0; s--) begin
      if (off_red >= 17'(RING_SIZE << s)) begin
        off_red = off_red - 17'(RING_SIZE << s);
      end
    end
  end

  assign nib_len = {1'b0, m_b1[3:0]} + LEN_W'(LEN_BIAS);
  assign n_match = (nib_len > MAX_LEN) ? MAX_LEN : nib_len;
  assign n_emit  = emit_match ? n_match :
                   (emit_lit || emit_raw) ? LEN_W'(1) : '0;

  assign sum    = {1'b0, bw_e} + (SIZE_W+1)'(n_emit);
  assign sum_ge = sum >= {1'b0, size_r};
  assign diff   = size_r - bw_e;
  assign take   = bw_ge ? '0 : (sum_ge ? diff[LEN_W-1:0] : n_emit);

  always_comb begin
    if (fin0) begin
      bw_nxt  = bw_e;
      fin_nxt = 1'b1;
    end else begin
      bw_nxt  = bw_ge ? bw_e : (sum_ge ? size_r : sum[SIZE_W-1:0]);
      fin_nxt = end_mark || (phase_nxt == PH_HDR_HI && (bw_ge || sum_ge));
    end
  end

  assign push               = accept;
  assign push_cmd.init      = init_ring;
  assign push_cmd.from_ring = emit_match;
  assign push_cmd.wr        = emit_match || emit_lit;
  assign push_cmd.empty     = (n_emit == '0);
  assign push_cmd.done      = fin_nxt;
  assign push_cmd.data      = lit_byte;
  assign push_cmd.off       = off_red[OFF_W-1:0];
  assign push_cmd.len       = (n_emit == '0) ? LEN_W'(1) : n_emit;
  assign push_cmd.take      = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR_HI;
      hh_r    <= 8'd0;
      bbl_r   <= 16'd0;
      fs_r    <= 8'd0;
      fl_r    <= 4'd0;
      mfb_r   <= 8'd0;
      bw_r    <= '0;
      fin_r   <= 1'b0;
      size_r  <= '0;
    end else begin
      if (cfg_valid) begin
        size_r <= cfg_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        hh_r    <= hh_nxt;
        bbl_r   <= bbl_nxt;
        fs_r    <= fs_nxt;
        fl_r    <= fl_nxt;
        mfb_r   <= mfb_nxt;
        bw_r    <= bw_nxt;
        fin_r   <= fin_nxt;
      end
    end
  end

endmodule

// ===== src/lzbd_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on lzbd_pkg for the command type.
module lzbd_cmd_fifo
  import lzbd_pkg::*;
#(
  parameter int DEPTH = DEF_CMD_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          q_mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== src/lzbd_back.sv =====
// Back end: expands commands into result beats, owns the history ring
// and the output register. Depends on lzbd_pkg.
module lzbd_back
  import lzbd_pkg::*;
#(
  parameter int RING_SIZE = DEF_RING_SIZE,
  parameter int MAX_MATCH = DEF_MAX_MATCH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              head_cmd,
  input  logic              fifo_empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic [TU_W-1:0]   out_tuser
);

  localparam int AW = $clog2(RING_SIZE);
  localparam int FW = $clog2(RING_SIZE + 1);
  localparam int KW = (MAX_MATCH > 1) ? $clog2(MAX_MATCH) : 1;
  localparam logic [AW-1:0] WR_INIT   = AW'(RING_SIZE - MAX_MATCH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_SIZE - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(RING_SIZE);

  logic [BYTE_W-1:0] ring_mem [RING_SIZE];
  logic [BYTE_W-1:0] mem_q_r;

  logic [AW-1:0]     wpos_r, ra_r, ra;
  logic [FW-1:0]     fill_r, fill_cur, ring_dist;
  logic [KW-1:0]     k_r;

  logic              s1_valid_r, s1_mem_r, s1_bv_r, s1_empty_r, s1_last_r;
  logic              s1_done_r, s1_wr_r, s1_init_r;
  logic [BYTE_W-1:0] s1_byte_r, s1_val;
  logic              s1_mem_nxt;
  logic [BYTE_W-1:0] s1_byte_nxt, init_byte;

  logic              out_tvalid_r, out_last_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [TU_W-1:0]   out_user_r;

  logic adv, issue, k_last, slot_bv, s1_we, fwd, filled, hi_zone;

  assign adv    = !out_tvalid_r || out_tready;
  assign issue  = adv && !fifo_empty;
  assign k_last = (LEN_W'(k_r) == head_cmd.len - LEN_W'(1));
  assign pop    = issue && k_last;
  assign ra     = (k_r == '0) ? head_cmd.off[AW-1:0] : ra_r;

  assign slot_bv  = LEN_W'(k_r) < head_cmd.take;
  assign s1_val   = s1_mem_r ? mem_q_r : s1_byte_r;
  assign s1_we    = adv && s1_valid_r && s1_wr_r;
  assign fill_cur = (s1_valid_r && s1_init_r) ? '0 : fill_r;
  assign fwd      = head_cmd.from_ring && s1_we && (ra == wpos_r);

  assign hi_zone   = ra >= WR_INIT;
  assign ring_dist = hi_zone ? FW'(ra) - FW'(WR_INIT) : FW'(ra) + FW'(MAX_MATCH);
  assign filled    = ring_dist < fill_cur;
  assign init_byte = hi_zone ? '0 : FILL_BYTE;

  assign s1_mem_nxt  = head_cmd.from_ring && !fwd && filled;
  assign s1_byte_nxt = !head_cmd.from_ring ? head_cmd.data :
                       fwd ? s1_val : init_byte;

  always_ff @(posedge clk) begin
    if (s1_we) begin
      ring_mem[wpos_r] <= s1_val;
    end
    if (issue && head_cmd.from_ring) begin
      mem_q_r <= ring_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_mem_r   <= s1_mem_nxt;
      s1_byte_r  <= s1_byte_nxt;
      s1_bv_r    <= slot_bv;
      s1_empty_r <= head_cmd.empty;
      s1_last_r  <= k_last;
      s1_done_r  <= head_cmd.done;
      s1_wr_r    <= head_cmd.wr;
      s1_init_r  <= head_cmd.init;
      ra_r       <= (ra == LAST_ADDR) ? '0 : ra + AW'(1);
    end
    if (adv) begin
      out_byte_r <= s1_bv_r ? s1_val : '0;
      out_last_r <= s1_last_r;
      out_user_r[TU_VALID] <= s1_bv_r;
      out_user_r[TU_DONE]  <= s1_done_r;
      out_user_r[TU_OVF]   <= !s1_bv_r && !s1_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      k_r          <= '0;
      wpos_r       <= WR_INIT;
      fill_r       <= '0;
    end else begin
      if (adv) begin
        out_tvalid_r <= s1_valid_r;
        s1_valid_r   <= issue;
        if (s1_valid_r && s1_init_r) begin
          wpos_r <= WR_INIT;
          fill_r <= '0;
        end else if (s1_we) begin
          wpos_r <= (wpos_r == LAST_ADDR) ? '0 : wpos_r + AW'(1);
          fill_r <= (fill_r == FILL_FULL) ? fill_r : fill_r + FW'(1);
        end
      end
      if (issue) begin
        k_r <= k_last ? '0 : k_r + KW'(1);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/lzss_block_stream_decoder.sv =====
// Top level of the LZSS block stream decoder: front end, command queue
// and back end. Depends on lzbd_pkg, lzbd_front, lzbd_cmd_fifo, lzbd_back.
//
//  channel  direction  handshake             payload
//  in_      slave      in_tvalid/in_tready   tdata: in_byte; tuser: start_req
//  out_     master     out_tvalid/out_tready tdata: out_byte; tlast: last_of_run;
//                                             tuser: byte_valid, done_res, overflow
//  cfg_     slave      cfg_valid/cfg_ready   data: output_size
//
// Each input beat becomes one queue entry; the back end then makes one result beat
// per cycle while out_tready allows, set by the single history ring read port: a copy
// gives 3 to MAX_MATCH result beats, every other input beat 1. The first result beat
// passes through the queue, the stage-1 register and the output register.
// Reset is synchronous; the ring needs no clearing pass (a fill count tracks it).
// A low out_tready freezes the back end; the queue absorbs CMD_DEPTH input beats.
module lzss_block_stream_decoder
  import lzbd_pkg::*;
#(
  parameter int RING_SIZE = DEF_RING_SIZE,
  parameter int MAX_MATCH = DEF_MAX_MATCH,
  parameter int CMD_DEPTH = DEF_CMD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic              in_tuser,   // [0] start_req
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic              out_tlast,
  output logic [TU_W-1:0]   out_tuser   // [0] byte_valid, [1] done_res, [2] overflow
);

  logic push, fifo_full, fifo_empty, pop;
  cmd_t push_cmd, head_cmd;

  lzbd_front #(
    .RING_SIZE(RING_SIZE),
    .MAX_MATCH(MAX_MATCH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .push_cmd (push_cmd),
    .fifo_full(fifo_full)
  );

  lzbd_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (fifo_full),
    .pop     (pop),
    .head_cmd(head_cmd),
    .empty   (fifo_empty)
  );

  lzbd_back #(
    .RING_SIZE(RING_SIZE),
    .MAX_MATCH(MAX_MATCH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .fifo_empty(fifo_empty),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

`ifndef SYNTHESIS
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[TU_VALID] |-> out_tdata == '0)
    else $error("undelivered result carries a nonzero byte");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TU_OVF] |-> !out_tuser[TU_VALID])
    else $error("dropped byte flagged as delivered");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run of results");

  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tuser[TU_DONE] == $past(out_tuser[TU_DONE]))
    else $error("done flag changed inside a run");
`endif

endmodule
